[design/assert_macros.svh]
// Assertion macros shared by the spike detector RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a consequent in the same cycle as its antecedent
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/spkd_pkg.sv]
// Types, constants and helpers for the spike detector
package spkd_pkg;

    // Input beat
    typedef struct packed {
        logic               mode;
        logic signed [15:0] voltage;
    } spkd_in_t;

    // Result beat
    typedef struct packed {
        logic [31:0] isi_ticks;
        logic        spike_onset;
        logic [31:0] spike_total;
        logic [2:0]  phase;
    } spkd_out_t;

    // Configuration register file
    typedef struct packed {
        logic signed [15:0] threshold;
        logic [15:0]        refractory_ticks;
        logic [15:0]        plateau_ticks;
    } spkd_cfg_t;

    // Input stage status toward the engine
    typedef struct packed {
        logic valid;
        logic advance;
    } spkd_stage_t;

    // Register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REFRACTORY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PLATEAU    = 2'd2;

    // Register reset values
    localparam logic signed [15:0] THRESHOLD_RST  = -16'sd2000;
    localparam logic [15:0]        REFRACTORY_RST = 16'd50;
    localparam logic [15:0]        PLATEAU_RST    = 16'd0;

    // Reported phase codes
    localparam logic [2:0] PHASE_CODE_ARMED   = 3'd0;
    localparam logic [2:0] PHASE_CODE_ONSET   = 3'd1;
    localparam logic [2:0] PHASE_CODE_CHECK   = 3'd2;
    localparam logic [2:0] PHASE_CODE_SHORT   = 3'd3;
    localparam logic [2:0] PHASE_CODE_PLATEAU = 3'd4;
    localparam logic [2:0] PHASE_CODE_REFRACT = 3'd5;

    localparam logic [31:0] SPIKE_MAX = 32'hFFFF_FFFF;

    // Detector phase, one-hot
    typedef enum logic [5:0] {
        PH_ARMED   = 6'b000001,
        PH_ONSET   = 6'b000010,
        PH_CHECK   = 6'b000100,
        PH_SHORT   = 6'b001000,
        PH_PLATEAU = 6'b010000,
        PH_REFRACT = 6'b100000
    } spkd_phase_t;

    // Map the one-hot phase to its reported code
    function automatic logic [2:0] phase_code(spkd_phase_t p);
        logic [2:0] code;
        case (p)
            PH_ARMED:   code = PHASE_CODE_ARMED;
            PH_ONSET:   code = PHASE_CODE_ONSET;
            PH_CHECK:   code = PHASE_CODE_CHECK;
            PH_SHORT:   code = PHASE_CODE_SHORT;
            PH_PLATEAU: code = PHASE_CODE_PLATEAU;
            PH_REFRACT: code = PHASE_CODE_REFRACT;
            default:    code = PHASE_CODE_ARMED;
        endcase
        return code;
    endfunction

endpackage

[design/spkd_in_stage.sv]
// Input register stage of the spike detector
module spkd_in_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  spkd_pkg::spkd_in_t in_data,
    input  logic              down_ready,
    output spkd_pkg::spkd_stage_t ctrl,
    output spkd_pkg::spkd_in_t item
);
    import spkd_pkg::*;

    logic     s1_valid_reg;
    logic     s1_valid_next;
    spkd_in_t s1_data_reg;
    logic     take;

    // Hold the beat while the result side cannot take it
    assign in_stall = s1_valid_reg & ~down_ready;
    assign take     = in_valid & ~in_stall;

    assign s1_valid_next = take | (s1_valid_reg & ~down_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // Capture the accepted beat
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_data_reg <= in_data;
        end
    end

    assign ctrl.valid   = s1_valid_reg;
    assign ctrl.advance = s1_valid_reg & down_ready;
    assign item         = s1_data_reg;

endmodule

[design/spkd_engine.sv]
// Detector phase machine, tick and spike counters, interval calculation
module spkd_engine
#(
    parameter int unsigned TIME_WIDTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  spkd_pkg::spkd_cfg_t   cfg,
    input  spkd_pkg::spkd_stage_t ctrl,
    input  spkd_pkg::spkd_in_t    item,
    output spkd_pkg::spkd_out_t   result
);
    import spkd_pkg::*;

    spkd_phase_t           phase_reg;
    spkd_phase_t           phase_next;
    spkd_phase_t           phase_step;
    logic [TIME_WIDTH-1:0] tick_reg;
    logic [TIME_WIDTH-1:0] tick_next;
    logic [TIME_WIDTH-1:0] last_spike_reg;
    logic [TIME_WIDTH-1:0] last_spike_next;
    logic [TIME_WIDTH-1:0] interval_reg;
    logic [TIME_WIDTH-1:0] interval_next;
    logic [31:0]           spikes_reg;
    logic [31:0]           spikes_next;
    logic [TIME_WIDTH-1:0] elapsed;
    logic                  above;
    logic                  below;
    logic                  past_plateau;
    logic                  past_refract;
    logic                  onset;

    // Compare the sample and the time since the last spike
    assign above        = item.voltage > cfg.threshold;
    assign below        = item.voltage < cfg.threshold;
    assign elapsed      = tick_reg - last_spike_reg;
    assign past_plateau = elapsed > TIME_WIDTH'(cfg.plateau_ticks);
    assign past_refract = elapsed > TIME_WIDTH'(cfg.refractory_ticks);

    // Advance the phase for a voltage sample
    always_comb
    begin
        phase_step = phase_reg;
        case (phase_reg)
            PH_ARMED:
            begin
                if (above)
                begin
                    phase_step = PH_ONSET;
                end
            end
            PH_ONSET:
            begin
                phase_step = PH_CHECK;
            end
            PH_CHECK:
            begin
                if (above && past_plateau)
                begin
                    phase_step = PH_PLATEAU;
                end
                else if (below)
                begin
                    phase_step = PH_SHORT;
                end
            end
            PH_SHORT:
            begin
                phase_step = PH_REFRACT;
            end
            PH_PLATEAU:
            begin
                if (below)
                begin
                    phase_step = PH_REFRACT;
                end
            end
            PH_REFRACT:
            begin
                if (past_refract)
                begin
                    phase_step = PH_ARMED;
                end
            end
            default:
            begin
                phase_step = PH_ARMED;
            end
        endcase
    end

    // Only an armed-to-onset move starts a spike
    assign onset = ~item.mode & (phase_step == PH_ONSET) & (phase_reg == PH_ARMED);

    // Build next state: clear drops everything, a sample advances the tick
    always_comb
    begin
        phase_next      = phase_reg;
        tick_next       = tick_reg;
        last_spike_next = last_spike_reg;
        interval_next   = interval_reg;
        spikes_next     = spikes_reg;
        if (item.mode)
        begin
            phase_next      = PH_ARMED;
            tick_next       = '0;
            last_spike_next = '0;
            interval_next   = '0;
            spikes_next     = '0;
        end
        else
        begin
            phase_next = phase_step;
            tick_next  = tick_reg + TIME_WIDTH'(1);
            if (onset)
            begin
                interval_next   = elapsed;
                last_spike_next = tick_reg;
                if (spikes_reg != SPIKE_MAX)
                begin
                    spikes_next = spikes_reg + 32'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_ARMED;
            tick_reg       <= '0;
            last_spike_reg <= '0;
            interval_reg   <= '0;
            spikes_reg     <= '0;
        end
        else if (ctrl.advance)
        begin
            phase_reg      <= phase_next;
            tick_reg       <= tick_next;
            last_spike_reg <= last_spike_next;
            interval_reg   <= interval_next;
            spikes_reg     <= spikes_next;
        end
    end

    // Result of this beat
    assign result.isi_ticks   = 32'(interval_next);
    assign result.spike_onset = onset;
    assign result.spike_total = spikes_next;
    assign result.phase       = phase_code(phase_next);

endmodule

[design/spike_detector_isi.sv]
// Top level of the threshold spike detector with refractory phase
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------
//  in      | in        | in_valid / in_stall | spkd_in_t (mode, voltage)
//  out     | out       | out_valid/out_stall | spkd_out_t (isi, onset, ...)
//  cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  One sample per cycle unless the output stalls; a taken beat is held in the
//  input register, then its result in the result register. The pace is set by
//  the combinational phase update and tick subtraction between the two.
//  Reset clears phase, counters and result valid and loads register defaults.
//  A stalled output holds its beat; the input stage holds one more beat.
module spike_detector_isi
#(
    parameter int unsigned TIME_WIDTH = 32
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  spkd_pkg::spkd_in_t             in_data,
    output logic                           out_valid,
    input  logic                           out_stall,
    output spkd_pkg::spkd_out_t            out_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [spkd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                    cfg_data
);
    import spkd_pkg::*;

`include "assert_macros.svh"

    spkd_cfg_t   cfg_reg;
    spkd_cfg_t   cfg_next;
    spkd_stage_t ctrl;
    spkd_in_t    item;
    spkd_out_t   result;
    spkd_out_t   out_data_reg;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        down_ready;

    // Register writes
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_THRESHOLD:  cfg_next.threshold        = cfg_data;
                CFG_REFRACTORY: cfg_next.refractory_ticks = cfg_data;
                CFG_PLATEAU:    cfg_next.plateau_ticks    = cfg_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold        <= THRESHOLD_RST;
            cfg_reg.refractory_ticks <= REFRACTORY_RST;
            cfg_reg.plateau_ticks    <= PLATEAU_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Result slot frees up when empty or being taken
    assign down_ready = ~out_valid_reg | ~out_stall;

    spkd_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .down_ready (down_ready),
        .ctrl       (ctrl),
        .item       (item)
    );

    spkd_engine #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_engine
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .ctrl   (ctrl),
        .item   (item),
        .result (result)
    );

    // Result register
    assign out_valid_next = ctrl.advance | (out_valid_reg & out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.advance)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Checks
    `ASSERT_SAME(a_stall_needs_beat, clk, rst_n, in_stall, ctrl.valid,
        "input stalled with an empty input stage")
    `ASSERT_SAME(a_onset_consistent, clk, rst_n, out_valid && out_data.spike_onset,
        out_data.phase == PHASE_CODE_ONSET && out_data.spike_total != 32'd0,
        "spike onset without onset phase or count")
    `ASSERT_NEXT(a_clear_result, clk, rst_n, ctrl.advance && item.mode,
        out_valid && out_data.spike_total == 32'd0 && out_data.isi_ticks == 32'd0
        && out_data.phase == PHASE_CODE_ARMED,
        "clear beat did not give a cleared result")
    `ASSERT_NEXT(a_advance_fills, clk, rst_n, ctrl.advance, out_valid,
        "processed beat did not reach the result register")

endmodule
